// File: design/fest_pkg.sv
// Package for the flow event statistics table: sizes, event codes, entry record and states.
package fest_pkg;

	localparam int MAX_FLOWS = 64;
	localparam int IDX_W     = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int CNT_W     = $clog2(MAX_FLOWS + 1);

	localparam int FID_W  = 16;
	localparam int CODE_W = 3;
	localparam int TS_W   = 32;
	localparam int PKT_W  = 32;
	localparam int TRN_W  = 16;
	localparam int OCNT_W = 7;

	// Event codes
	localparam logic [CODE_W-1:0] EV_SEND = 3'd0;
	localparam logic [CODE_W-1:0] EV_ENQ  = 3'd1;
	localparam logic [CODE_W-1:0] EV_RECV = 3'd3;
	localparam logic [CODE_W-1:0] EV_DROP = 3'd4;

	localparam logic [PKT_W-1:0] PKT_MAX = '1;
	localparam logic [TRN_W-1:0] TRN_MAX = '1;

	// One stored flow entry (flow id kept in its own RAM)
	typedef struct packed {
		logic [TS_W-1:0]  last_time;
		logic [TS_W-1:0]  first_time;
		logic [TRN_W-1:0] in_transit;
		logic [PKT_W-1:0] lost;
		logic [PKT_W-1:0] sent;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

endpackage

// File: design/fest_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fest_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/flow_event_statistics_table.sv
// Top level of the flow event statistics table: lookup sequencer, entry RAMs and result register.
//
// Channel  Dir  Handshake           Contents
// s_*      in   s_tvalid/s_tready   trace event: flow_id, event_code, timestamp
// m_*      out  m_tvalid/m_tready   flags in m_tuser, counts and flow statistics in m_tdata
//
// During an event the flow-id RAM read port scans one stored entry per cycle through one
// shared comparator, then the update step writes the entry. A hit ends the scan early.
// Entries fill in order, so the fill count marks valid entries; no clearing pass is needed.
// Reset clears the fill and active counts and the sequencer; s_tready is high only when idle.
// The update step holds while an earlier result waits in the output register.
module flow_event_statistics_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] flow_id, [18:16] event_code, [50:19] timestamp, [55:51] zero
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] new_flow, [1] table_full, [2] active_changed
	output logic [2:0]   m_tuser,
	// [6:0] active_flows, [13:7] known_flows, [45:14] sent_packets, [77:46] lost_packets,
	// [93:78] packets_in_transit, [125:94] first_seen, [157:126] last_seen, [159:158] zero
	output logic [159:0] m_tdata
);

	localparam int IDX_W = fest_pkg::IDX_W;
	localparam int CNT_W = fest_pkg::CNT_W;

	fest_pkg::state_t state_q;

	// Latched event
	logic [fest_pkg::FID_W-1:0]  fid_q;
	logic [fest_pkg::CODE_W-1:0] code_q;
	logic [fest_pkg::TS_W-1:0]   ts_q;

	// Global counts
	logic [CNT_W-1:0] flow_total_q;
	logic [CNT_W-1:0] active_total_q;

	// Scan control
	logic [CNT_W-1:0] issue_q;
	logic             pend_q;
	logic [IDX_W-1:0] pidx_q;

	// Working entry
	fest_pkg::rec_t   wrk_q;
	logic [IDX_W-1:0] k_q;
	logic             created_q;
	logic             full_q;

	// Output register
	logic         m_tvalid_q;
	logic [2:0]   m_tuser_q;
	logic [159:0] m_tdata_q;

	// RAM ports
	logic [fest_pkg::FID_W-1:0] id_rdata;
	fest_pkg::rec_t             rec_rdata;
	fest_pkg::rec_t             rec_new;
	logic                       id_we;
	logic                       rec_we;

	logic s_xfer;
	logic issuing;
	logic match;
	logic proceed;
	logic rise;
	logic fall;
	logic changed;
	logic [CNT_W-1:0] flow_total_n;
	logic [CNT_W-1:0] active_total_n;

	assign s_tready = (state_q == fest_pkg::ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;

	// Shared comparator over the scanned entries
	assign issuing = (state_q == fest_pkg::ST_SCAN) && (issue_q < flow_total_q);
	assign match   = pend_q && (id_rdata == fid_q);

	assign proceed = (state_q == fest_pkg::ST_UPD) && (!m_tvalid_q || m_tready);

	fest_ram #(
		.WIDTH(fest_pkg::FID_W),
		.DEPTH(fest_pkg::MAX_FLOWS)
	) u_id_ram (
		.clk  (clk),
		.we   (id_we),
		.waddr(k_q),
		.wdata(fid_q),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(id_rdata)
	);

	fest_ram #(
		.WIDTH(fest_pkg::REC_W),
		.DEPTH(fest_pkg::MAX_FLOWS)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(k_q),
		.wdata(rec_new),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(rec_rdata)
	);

	assign id_we  = proceed && created_q;
	assign rec_we = proceed && !full_q;

	// Entry update for the current event
	always_comb begin
		rise = (code_q == fest_pkg::EV_SEND) || (code_q == fest_pkg::EV_ENQ);
		fall = (code_q == fest_pkg::EV_RECV) || (code_q == fest_pkg::EV_DROP);
		rec_new = wrk_q;
		rec_new.last_time = ts_q;
		if (code_q == fest_pkg::EV_SEND && wrk_q.sent != fest_pkg::PKT_MAX) begin
			rec_new.sent = wrk_q.sent + 1'b1;
		end
		if (code_q == fest_pkg::EV_DROP && wrk_q.lost != fest_pkg::PKT_MAX) begin
			rec_new.lost = wrk_q.lost + 1'b1;
		end
		if (rise && wrk_q.in_transit != fest_pkg::TRN_MAX) begin
			rec_new.in_transit = wrk_q.in_transit + 1'b1;
		end else if (fall && wrk_q.in_transit != '0) begin
			rec_new.in_transit = wrk_q.in_transit - 1'b1;
		end
		changed        = 1'b0;
		active_total_n = active_total_q;
		if (!full_q) begin
			if (rise && wrk_q.in_transit == '0) begin
				changed        = 1'b1;
				active_total_n = active_total_q + CNT_W'(1);
			end else if (fall && wrk_q.in_transit == fest_pkg::TRN_W'(1)
					&& active_total_q != '0) begin
				changed        = 1'b1;
				active_total_n = active_total_q - CNT_W'(1);
			end
		end
		flow_total_n = created_q ? flow_total_q + CNT_W'(1) : flow_total_q;
	end

	// Sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fest_pkg::ST_IDLE;
			flow_total_q   <= '0;
			active_total_q <= '0;
			pend_q         <= 1'b0;
			issue_q        <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (proceed) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				fest_pkg::ST_IDLE: begin
					pend_q  <= 1'b0;
					issue_q <= '0;
					if (s_xfer) begin
						state_q <= fest_pkg::ST_SCAN;
					end
				end
				fest_pkg::ST_SCAN: begin
					pend_q <= issuing;
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (match || !issuing) begin
						state_q <= fest_pkg::ST_UPD;
					end
				end
				fest_pkg::ST_UPD: begin
					if (proceed) begin
						flow_total_q   <= flow_total_n;
						active_total_q <= active_total_n;
						state_q        <= fest_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fest_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload: event latch, scan tracking, working entry, result
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			fid_q  <= s_tdata[15:0];
			code_q <= s_tdata[18:16];
			ts_q   <= s_tdata[50:19];
		end
		if (issuing) begin
			pidx_q <= issue_q[IDX_W-1:0];
		end
		if (state_q == fest_pkg::ST_SCAN) begin
			if (match) begin
				wrk_q     <= rec_rdata;
				k_q       <= pidx_q;
				created_q <= 1'b0;
				full_q    <= 1'b0;
			end else if (!issuing) begin
				// fresh entry: zero counters, first and last time from the event
				wrk_q     <= {ts_q, ts_q, fest_pkg::TRN_W'(0), fest_pkg::PKT_W'(0),
					fest_pkg::PKT_W'(0)};
				k_q       <= flow_total_q[IDX_W-1:0];
				created_q <= (flow_total_q < CNT_W'(fest_pkg::MAX_FLOWS));
				full_q    <= !(flow_total_q < CNT_W'(fest_pkg::MAX_FLOWS));
			end
		end
		if (proceed) begin
			m_tuser_q <= {changed, full_q, created_q};
			m_tdata_q[6:0]  <= fest_pkg::OCNT_W'(active_total_n);
			m_tdata_q[13:7] <= fest_pkg::OCNT_W'(flow_total_n);
			if (full_q) begin
				m_tdata_q[159:14] <= '0;
			end else begin
				m_tdata_q[45:14]   <= rec_new.sent;
				m_tdata_q[77:46]   <= rec_new.lost;
				m_tdata_q[93:78]   <= rec_new.in_transit;
				m_tdata_q[125:94]  <= rec_new.first_time;
				m_tdata_q[157:126] <= rec_new.last_time;
				m_tdata_q[159:158] <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// Fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flow_total_q <= CNT_W'(fest_pkg::MAX_FLOWS))
		else $error("fill count above table size");

	// Active flows are always a subset of stored flows
	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_total_q <= flow_total_q)
		else $error("active count above stored count");

	// A full-table result never claims a new entry or an active change
	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && !m_tuser[2]))
		else $error("table full result with other flags set");

	// Creating an entry bumps the fill count by one
	a_create_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && created_q) |=> (flow_total_q == $past(flow_total_q) + CNT_W'(1)))
		else $error("fill count not advanced on new entry");

endmodule
